// ===== rtl/core/vcc_pkg.sv =====
`timescale 1ns / 1ps

package vcc_pkg;

  localparam int SPEED_W    = 16;
  localparam int VIOL_W     = 18;
  localparam int PROD_W     = 34;
  localparam int SUM_W      = 48;
  localparam int COST_W     = 32;
  localparam int POWER_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic signed [SPEED_W-1:0] RST_MAX_SPEED  = 16'sd2048;
  localparam logic signed [SPEED_W-1:0] RST_MIN_SPEED  = -16'sd1434;
  localparam logic [15:0]               RST_MIN_RADIUS = 16'd0;
  localparam logic [15:0]               RST_STEP_TIME  = 16'd6554;
  localparam logic [15:0]               RST_WEIGHT     = 16'd1024;
  localparam logic [POWER_W-1:0]        RST_POWER      = 3'd1;

  localparam logic [COST_W-1:0] COST_SAT = '1;
  localparam logic [COST_W-1:0] COST_ONE = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_TURN_MODE,
    REG_MAX_SPEED,
    REG_MIN_SPEED,
    REG_MIN_RADIUS,
    REG_STEP_TIME,
    REG_WEIGHT,
    REG_POWER
  } vcc_reg_t;

  typedef struct packed {
    logic                       enable;
    logic                       turn_mode;
    logic signed [SPEED_W-1:0]  max_speed;
    logic signed [SPEED_W-1:0]  min_speed;
    logic [15:0]                min_radius;
    logic [15:0]                step_time;
    logic [15:0]                weight;
    logic [POWER_W-1:0]         power;
  } vcc_cfg_t;

  // one classified request waiting for the back end
  typedef struct packed {
    logic [16:0] speed_viol;
    logic [15:0] abs_speed;
    logic [15:0] abs_yaw;
    logic        need_turn;
    logic        zero_cost;
    logic        last;
  } vcc_entry_t;

endpackage

// ===== rtl/core/vcc_front.sv =====
`timescale 1ns / 1ps

module vcc_front (
  input  vcc_pkg::vcc_cfg_t          cfg,
  input  logic signed [15:0]         speed_x,
  input  logic signed [15:0]         yaw_rate,
  input  logic                       last_sample,
  output vcc_pkg::vcc_entry_t        entry
);
  import vcc_pkg::*;

  logic signed [16:0] sx, mx, nx, d_hi, d_lo;
  logic [16:0]        sx_u, wy_u, neg_sx, neg_wy;
  logic [15:0]        excess, shortfall, abs_speed, abs_yaw;

  always_comb begin
    sx   = 17'(speed_x);
    mx   = 17'(cfg.max_speed);
    nx   = 17'(cfg.min_speed);
    d_hi = sx - mx;
    d_lo = nx - sx;
    excess    = (!d_hi[16] && d_hi != 17'sd0) ? d_hi[15:0] : 16'd0;
    shortfall = (!d_lo[16] && d_lo != 17'sd0) ? d_lo[15:0] : 16'd0;

    sx_u   = {speed_x[15], speed_x};
    wy_u   = {yaw_rate[15], yaw_rate};
    neg_sx = 17'd0 - sx_u;
    neg_wy = 17'd0 - wy_u;
    abs_speed = speed_x[15]  ? neg_sx[15:0] : sx_u[15:0];
    abs_yaw   = yaw_rate[15] ? neg_wy[15:0] : wy_u[15:0];

    entry.speed_viol = cfg.enable ? ({1'b0, excess} + {1'b0, shortfall}) : 17'd0;
    entry.abs_speed  = abs_speed;
    entry.abs_yaw    = abs_yaw;
    // ratio of 2^16 or more can never fall below the radius
    entry.need_turn  = cfg.enable && cfg.turn_mode && (abs_yaw != 16'd0) &&
                       ({4'd0, abs_speed} < {abs_yaw, 4'd0});
    entry.zero_cost  = !cfg.enable;
    entry.last       = last_sample;
  end

endmodule

// ===== rtl/core/vcc_queue.sv =====
`timescale 1ns / 1ps

module vcc_queue #(
  parameter int DEPTH = vcc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  vcc_pkg::vcc_entry_t push_data,
  output logic                head_valid,
  input  logic                pop,
  output vcc_pkg::vcc_entry_t head_data
);
  import vcc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  vcc_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/vcc_back.sv =====
`timescale 1ns / 1ps

module vcc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vcc_pkg::vcc_cfg_t   cfg,
  input  logic                head_valid,
  input  vcc_pkg::vcc_entry_t head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_cost
);
  import vcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_TURN,
    S_MUL,
    S_ACC,
    S_WGT,
    S_PWR,
    S_EMIT
  } state_t;

  state_t              state_r;
  vcc_entry_t          ent_r;
  logic [15:0]         rem_r, nlo_r, quo_r;
  logic [3:0]          bit_cnt_r;
  logic [VIOL_W-1:0]   viol_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SUM_W-1:0]    sum_r;
  logic [COST_W-1:0]   x_r, y_r, cost_r, out_cost_r;
  logic [POWER_W-1:0]  pcnt_r;
  logic                out_valid_r;

  logic [16:0]         rem_sh, rem_diff;
  logic                rem_ge;
  logic [15:0]         turn;
  logic [SUM_W:0]      sum_add;
  logic [63:0]         wprod, pprod;
  logic [43:0]         x_full;
  logic [POWER_W-1:0]  pcnt_nxt;
  logic                load_out;

  assign pop       = (state_r == S_IDLE) && head_valid;
  assign out_valid = out_valid_r;
  assign out_cost  = out_cost_r;
  assign load_out  = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    rem_sh   = {rem_r, nlo_r[15]};
    rem_diff = rem_sh - {1'b0, ent_r.abs_yaw};
    rem_ge   = !rem_diff[16];
    turn     = (quo_r < cfg.min_radius) ? (cfg.min_radius - quo_r) : 16'd0;
    sum_add  = {1'b0, sum_r} + (SUM_W + 1)'(prod_r);
    wprod    = 64'(sum_r) * 64'(cfg.weight);
    x_full   = wprod[63:20];
    pprod    = 64'(y_r) * 64'(x_r);
    pcnt_nxt = pcnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (head_valid) begin
            ent_r     <= head_data;
            viol_r    <= {1'b0, head_data.speed_viol};
            rem_r     <= {4'd0, head_data.abs_speed[15:4]};
            nlo_r     <= {head_data.abs_speed[3:0], 12'd0};
            quo_r     <= '0;
            bit_cnt_r <= '0;
            if (head_data.zero_cost) begin
              if (head_data.last) begin
                cost_r  <= '0;
                sum_r   <= '0;
                state_r <= S_EMIT;
              end
            end else if (head_data.need_turn) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_DIV: begin
          rem_r     <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
          quo_r     <= {quo_r[14:0], rem_ge};
          nlo_r     <= {nlo_r[14:0], 1'b0};
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (bit_cnt_r == 4'hF) begin
            state_r <= S_TURN;
          end
        end
        S_TURN: begin
          viol_r  <= viol_r + VIOL_W'(turn);
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PROD_W'(viol_r) * PROD_W'(cfg.step_time);
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          state_r <= ent_r.last ? S_WGT : S_IDLE;
        end
        S_WGT: begin
          sum_r  <= '0;
          x_r    <= x_full[31:0];
          y_r    <= x_full[31:0];
          pcnt_r <= POWER_W'(1);
          priority if (cfg.power == '0) begin
            cost_r  <= COST_ONE;
            state_r <= S_EMIT;
          end else if (|x_full[43:32]) begin
            cost_r  <= COST_SAT;
            state_r <= S_EMIT;
          end else if (cfg.power == POWER_W'(1)) begin
            cost_r  <= x_full[31:0];
            state_r <= S_EMIT;
          end else begin
            state_r <= S_PWR;
          end
        end
        S_PWR: begin
          y_r    <= pprod[47:16];
          pcnt_r <= pcnt_nxt;
          priority if (|pprod[63:48]) begin
            cost_r  <= COST_SAT;
            state_r <= S_EMIT;
          end else if (pcnt_nxt == cfg.power) begin
            cost_r  <= pprod[47:16];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            out_cost_r <= cost_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/velocity_constraint_cost.sv =====
`timescale 1ns / 1ps
// Trajectory speed-limit cost.
// Input channel (in_valid/in_ready): one request per trajectory sample with
// forward speed, yaw rate and a last-sample flag. Output channel
// (out_valid/out_ready): one Q16.16 cost per trajectory, on its last sample.
// Config channel (cfg_valid/cfg_ready, always ready): register index and
// data; write only while no request is in flight.
// Back end: each sample passes idle, multiply and accumulate states (idle
// only when disabled), preceded by the 16-step shift-subtract divider and a
// radius step when the turning-radius term is needed; an enabled last sample
// adds weighting, up to 6 extra power steps and the output load. The front end
// classifies each request in the cycle it is accepted and parks it in a
// small queue, so input is taken while the back end is busy until it fills.
// A last sample's cost also waits for any queued samples ahead of it.
// Reset: registers return to their defaults, the running sum and the queue
// are cleared. A stalled receiver holds the result in the output register;
// the back end then waits before loading the next cost, and the queue fills.
module velocity_constraint_cost #(
  parameter int QUEUE_DEPTH = vcc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_speed_x,
  input  logic signed [15:0] in_yaw_rate,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_trajectory_cost,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [vcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vcc_pkg::*;

  vcc_cfg_t   cfg_r;
  vcc_entry_t front_entry, head_data;
  logic       head_valid, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable     <= 1'b1;
      cfg_r.turn_mode  <= 1'b0;
      cfg_r.max_speed  <= RST_MAX_SPEED;
      cfg_r.min_speed  <= RST_MIN_SPEED;
      cfg_r.min_radius <= RST_MIN_RADIUS;
      cfg_r.step_time  <= RST_STEP_TIME;
      cfg_r.weight     <= RST_WEIGHT;
      cfg_r.power      <= RST_POWER;
    end else if (cfg_valid) begin
      unique case (vcc_reg_t'(cfg_index))
        REG_ENABLE:     cfg_r.enable     <= cfg_data[0];
        REG_TURN_MODE:  cfg_r.turn_mode  <= cfg_data[0];
        REG_MAX_SPEED:  cfg_r.max_speed  <= cfg_data;
        REG_MIN_SPEED:  cfg_r.min_speed  <= cfg_data;
        REG_MIN_RADIUS: cfg_r.min_radius <= cfg_data;
        REG_STEP_TIME:  cfg_r.step_time  <= cfg_data;
        REG_WEIGHT:     cfg_r.weight     <= cfg_data;
        REG_POWER:      cfg_r.power      <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  vcc_front u_front (
    .cfg         (cfg_r),
    .speed_x     (in_speed_x),
    .yaw_rate    (in_yaw_rate),
    .last_sample (in_last_sample),
    .entry       (front_entry)
  );

  vcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  vcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_cost   (out_trajectory_cost)
  );

endmodule

// ===== tb/vcc_checker.sv =====
`timescale 1ns / 1ps

module vcc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [15:0]             in_speed_x,
  input  logic signed [15:0]             in_yaw_rate,
  input  logic                           in_last_sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [31:0]                    out_trajectory_cost,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [vcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             error_count,
  output int                             costs_due
);
  import vcc_pkg::*;

  localparam logic [SUM_W-1:0] SUM_SAT = '1;

  vcc_cfg_t          regs;
  logic [SUM_W-1:0]  viol_sum;
  logic [COST_W-1:0] expected_costs[$];

  function automatic logic [COST_W-1:0] cost_of_sum(logic [SUM_W-1:0] total);
    logic [63:0] base;
    logic [63:0] acc;
    if (regs.power == '0) return COST_ONE;
    base = ({16'd0, total} * {48'd0, regs.weight}) >> 20;
    if (base > {32'd0, COST_SAT}) return COST_SAT;
    acc = base;
    for (int i = 1; i < regs.power; i++) begin
      acc = (acc * base) >> 16;
      if (acc > {32'd0, COST_SAT}) return COST_SAT;
    end
    return acc[COST_W-1:0];
  endfunction

  function automatic void accrue_violation(logic signed [15:0] speed,
                                           logic signed [15:0] yaw, logic last);
    int          v;
    int          w;
    int          hi;
    int          lo;
    int          over;
    int          under;
    logic [63:0] viol;
    logic [63:0] av;
    logic [63:0] aw;
    logic [63:0] ratio;
    viol = '0;
    if (regs.enable) begin
      v  = speed;
      w  = yaw;
      hi = $signed(regs.max_speed);
      lo = $signed(regs.min_speed);
      if (v > hi) begin
        over = v - hi;
        viol = viol + over;
      end
      if (lo > v) begin
        under = lo - v;
        viol  = viol + under;
      end
      if (regs.turn_mode && w != 0) begin
        av    = (v < 0) ? -v : v;
        aw    = (w < 0) ? -w : w;
        ratio = (av << 12) / aw;
        if (ratio < regs.min_radius) viol = viol + (regs.min_radius - ratio);
      end
      viol = viol * regs.step_time;
      if (viol > SUM_SAT - viol_sum) viol_sum = SUM_SAT;
      else viol_sum = viol_sum + viol[SUM_W-1:0];
    end
    if (last) begin
      expected_costs.push_back(regs.enable ? cost_of_sum(viol_sum) : '0);
      viol_sum = '0;
    end
  endfunction

  always @(posedge clk) begin
    logic [COST_W-1:0] want;
    if (!rst_n) begin
      regs = '{enable: 1'b1, turn_mode: 1'b0, max_speed: RST_MAX_SPEED,
               min_speed: RST_MIN_SPEED, min_radius: RST_MIN_RADIUS,
               step_time: RST_STEP_TIME, weight: RST_WEIGHT, power: RST_POWER};
      viol_sum = '0;
      expected_costs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (vcc_reg_t'(cfg_index))
          REG_ENABLE:     regs.enable     = cfg_data[0];
          REG_TURN_MODE:  regs.turn_mode  = cfg_data[0];
          REG_MAX_SPEED:  regs.max_speed  = cfg_data;
          REG_MIN_SPEED:  regs.min_speed  = cfg_data;
          REG_MIN_RADIUS: regs.min_radius = cfg_data;
          REG_STEP_TIME:  regs.step_time  = cfg_data;
          REG_WEIGHT:     regs.weight     = cfg_data;
          REG_POWER:      regs.power      = cfg_data[POWER_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_costs.size() == 0) begin
          $error("trajectory_cost expected none actual %0h", out_trajectory_cost);
          error_count <= error_count + 1;
        end else begin
          want = expected_costs.pop_front();
          if (out_trajectory_cost !== want) begin
            $error("trajectory_cost expected %0h actual %0h", want, out_trajectory_cost);
            error_count <= error_count + 1;
          end
        end
      end
      if (in_valid && in_ready) accrue_violation(in_speed_x, in_yaw_rate, in_last_sample);
    end
    costs_due <= expected_costs.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import vcc_pkg::*;

  localparam int DRAIN_HOLD    = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SAMPLES = 98;
  localparam int LONG_SAMPLES  = 24;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic signed [15:0]    in_speed_x     = '0;
  logic signed [15:0]    in_yaw_rate    = '0;
  logic                  in_last_sample = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b1;
  logic [31:0]           out_trajectory_cost;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  int                    error_count;
  int                    costs_due;

  int                    gap_odds   = 0;
  int                    stall_odds = 0;
  int                    stall_left = 0;
  int                    quiet      = 0;
  logic signed [15:0]    cur_max    = RST_MAX_SPEED;
  logic signed [15:0]    cur_min    = RST_MIN_SPEED;

  velocity_constraint_cost dut (.*);
  vcc_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
      stall_left = $urandom_range(1, 17);
    out_ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_sample(input logic signed [15:0] speed, input logic signed [15:0] yaw,
                             input logic last);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_speed_x     <= speed;
    in_yaw_rate    <= yaw;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait for every cost, then for samples still in the block's queue
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (costs_due != 0) @(posedge clk);
    repeat (DRAIN_HOLD) @(posedge clk);
  endtask

  task automatic write_reg(input vcc_reg_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic en, input logic turn,
                             input logic signed [15:0] hi, input logic signed [15:0] lo,
                             input logic [15:0] radius, input logic [15:0] step,
                             input logic [15:0] weight, input logic [2:0] power);
    write_reg(REG_ENABLE, {15'd0, en});
    write_reg(REG_TURN_MODE, {15'd0, turn});
    write_reg(REG_MAX_SPEED, hi);
    write_reg(REG_MIN_SPEED, lo);
    write_reg(REG_MIN_RADIUS, radius);
    write_reg(REG_STEP_TIME, step);
    write_reg(REG_WEIGHT, weight);
    write_reg(REG_POWER, {13'd0, power});
    cfg_valid <= 1'b0;
    cur_max = hi;
    cur_min = lo;
  endtask

  task automatic send_trajectory(input int len);
    logic signed [15:0] s;
    logic signed [15:0] y;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 4))
        0:       s = 16'($urandom());
        1:       s = 16'(int'(cur_max) + int'($urandom_range(0, 64)) - 32);
        2:       s = 16'(int'(cur_min) + int'($urandom_range(0, 64)) - 32);
        3:       s = 16'(int'($urandom_range(0, 2048)) - 1024);
        default: s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      endcase
      case ($urandom_range(0, 7))
        0:       y = '0;
        1:       y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        2, 3:    y = 16'(int'($urandom_range(0, 128)) - 64);
        default: y = 16'($urandom());
      endcase
      send_sample(s, y, i == len - 1);
    end
  endtask

  initial begin
    logic               en;
    logic               turn;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    logic [15:0]        radius;
    logic [15:0]        step;
    logic [15:0]        weight;
    int                 sent;
    int                 len;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: bounds, exact limits, field extremes
    send_sample(16'sh7fff, 16'sh0000, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 1'b0);
    send_sample(16'sd2049, -16'sd1, 1'b1);
    send_sample(16'sd2048, 16'sh0000, 1'b1);
    send_sample(-16'sd1435, 16'sd5, 1'b0);
    send_sample(-16'sd1434, 16'sh8000, 1'b1);

    // turning radius term, including zero yaw rate
    settle();
    load_config(1'b1, 1'b1, 16'sd2048, -16'sd1434, 16'hffff, 16'hffff, 16'd256, 3'd2);
    send_sample(16'sd0, 16'sd1, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sh7fff, 16'sd1, 1'b0);
    send_sample(16'sd4096, 16'sd4096, 1'b0);
    send_sample(16'sd100, 16'sh8000, 1'b1);

    // crossed bounds with cost overflow at the largest power
    settle();
    load_config(1'b1, 1'b0, 16'sh8000, 16'sh7fff, 16'd0, 16'hffff, 16'hffff, 3'd7);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sh7fff, 16'sd123, 1'b1);

    // power zero
    settle();
    load_config(1'b1, 1'b0, 16'sh7fff, 16'sh8000, 16'd0, 16'd1, 16'd1, 3'd0);
    send_sample(16'sd5, 16'sd5, 1'b1);

    // disabling mid trajectory drops the partial sum
    settle();
    load_config(1'b1, 1'b0, 16'sd0, 16'sd0, 16'd0, 16'hffff, 16'd256, 3'd1);
    send_sample(16'sh7fff, 16'sd0, 1'b0);
    settle();
    load_config(1'b0, 1'b0, 16'sd0, 16'sd0, 16'd0, 16'hffff, 16'd256, 3'd1);
    send_sample(16'sd1000, 16'sd0, 1'b1);
    settle();
    load_config(1'b1, 1'b0, 16'sd0, 16'sd0, 16'd0, 16'hffff, 16'd256, 3'd1);
    send_sample(16'sd0, 16'sd0, 1'b1);

    // long trajectory at full violation
    settle();
    load_config(1'b1, 1'b0, 16'sh8000, 16'sh7fff, 16'd0, 16'hffff, 16'd1, 3'd1);
    for (int i = 0; i < LONG_SAMPLES; i++)
      send_sample(16'($urandom()), 16'($urandom()), i == LONG_SAMPLES - 1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      en   = ($urandom_range(0, 7) != 0);
      turn = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0: begin
          hi = 16'($urandom_range(0, 16384));
          lo = 16'(-int'($urandom_range(0, 16384)));
        end
        1: begin
          hi = 16'($urandom());
          lo = 16'($urandom());
        end
        2: begin
          hi = 16'sh7fff;
          lo = 16'sh8000;
        end
        default: begin
          hi = 16'($urandom_range(0, 8192));
          lo = hi + 16'($urandom_range(0, 4096));
        end
      endcase
      radius = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 8192));
      case ($urandom_range(0, 3))
        0:       step = 16'd0;
        1:       step = 16'hffff;
        default: step = 16'($urandom());
      endcase
      weight = $urandom_range(0, 1) ? 16'($urandom_range(0, 512)) : 16'($urandom());
      load_config(en, turn, hi, lo, radius, step, weight, 3'($urandom_range(0, 7)));

      if (p == RANDOM_PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 10);
        stall_odds = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 10);
      end

      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        len = $urandom_range(0, 5) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_trajectory(len);
        sent += len;
      end
    end

    settle();
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
